@@ hw/rtl/cca_pkg.sv @@
package cca_pkg;

    localparam int PIXEL_COUNT_BITS_DEF = 32;
    localparam int WORD_W    = 32;
    localparam int MANT_W    = 31;          // Q1.30 mantissa
    localparam int LSUM_W    = 26;          // log-domain sum, signed Q.16
    localparam int EXPO_W    = 28;          // exponent F, signed Q.16
    localparam int OPND_W    = 33;          // shared multiplier operand
    localparam int PROD_W    = 2 * OPND_W;
    localparam int TERM_W    = 35;
    localparam int LOG_STEPS = 16;
    localparam int EXP_STEPS = 16;

    localparam logic [31:0] INITIAL_CHI_RST = 32'd0;
    localparam logic [15:0] CONCAVITY_RST   = 16'd7373;
    localparam logic [31:0] REF_AREA_RST    = 32'd65536;
    localparam logic [31:0] CELL_SIZE_RST   = 32'd65536;

    localparam logic [TERM_W-1:0] TERM_CAP  = TERM_W'(64'd1 << 33);
    localparam logic [31:0]       CHI_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0]       Q30_ONE   = 32'h4000_0000;
    localparam logic [LSUM_W-1:0] LOG_BIAS  = LSUM_W'(16 * 65536);
    localparam logic [EXPO_W-1:0] HALF_STEP = EXPO_W'(32768);

    typedef enum logic [1:0] {
        REG_INITIAL_CHI = 2'd0,
        REG_CONCAVITY   = 2'd1,
        REG_REF_AREA    = 2'd2,
        REG_CELL_SIZE   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        OPND_AREA  = 2'd0,
        OPND_CELL  = 2'd1,
        OPND_PIXEL = 2'd2
    } opnd_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_LOG,
        ST_SCALE,
        ST_EXP,
        ST_FINISH
    } state_t;

    typedef logic [31:0] root_tab_t [EXP_STEPS];

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = x;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // successive square roots of 2.0 in Q1.30
    function automatic root_tab_t build_roots();
        root_tab_t   tab;
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int i = 0; i < EXP_STEPS; i++) begin
            r      = isqrt64(r << 30);
            tab[i] = r[31:0];
        end
        return tab;
    endfunction

    localparam root_tab_t ROOTS = build_roots();

endpackage

@@ hw/rtl/cca_norm.sv @@
module cca_norm (
    input  logic [31:0]                 x,
    output logic [4:0]                  msb,
    output logic [cca_pkg::MANT_W-1:0]  mant
);

    logic [31:0] xs;

    always_comb
    begin
        msb = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                msb = 5'(i);
            end
        end
    end

    // top bit lands on bit 30
    always_comb
    begin
        if (msb == 5'd31) begin
            xs = x >> 1;
        end
        else begin
            xs = x << (5'd30 - msb);
        end
        mant = xs[cca_pkg::MANT_W-1:0];
    end

endmodule

@@ hw/rtl/chi_coordinate_accumulator.sv @@
// Chi coordinate accumulator.
// Nodes of one channel arrive on the input channel (in_valid/in_ready) from
// the outlet upward; each transaction carries is_outlet, diagonal_step and
// pixel_count. Every node yields one transaction on the output channel
// (out_valid/out_ready) with chi_value and saturated.
// An outlet node loads chi with initial_chi. Any other node runs three log2
// passes (area, cell size, pixel count), one scaling multiply and 16 exp2
// steps through one shared 33x33 multiplier, then the accumulate. One node
// is in flight at a time; in_ready is high only while the sequencer is idle.
// A finished result sits in an output register; the next node is accepted
// while it waits. If the receiver stalls, the sequencer holds its next result
// until the output register frees. Registers are written over
// cfg_write/cfg_addr/cfg_wdata; the user must write them only while idle,
// as the block itself does not enforce it.
// Reset clears running chi and restores register defaults.
module chi_coordinate_accumulator #(
    parameter int PIXEL_COUNT_BITS = cca_pkg::PIXEL_COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        is_outlet,
    input  logic        diagonal_step,
    input  logic [31:0] pixel_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] chi_value,
    output logic        saturated
);

    localparam int PW = (PIXEL_COUNT_BITS < 32) ? PIXEL_COUNT_BITS : 32;
    localparam logic [32:0] PIX_MASK_W = (33'd1 << PW) - 33'd1;
    localparam logic [31:0] PIX_MASK   = PIX_MASK_W[31:0];

    localparam int MW = cca_pkg::MANT_W;
    localparam int LW = cca_pkg::LSUM_W;
    localparam int FW = cca_pkg::EXPO_W;
    localparam int OW = cca_pkg::OPND_W;
    localparam int PRW = cca_pkg::PROD_W;
    localparam int TW = cca_pkg::TERM_W;

    cca_pkg::state_t state_reg, state_next;

    logic [31:0] initial_chi_reg, ref_area_reg, cell_size_reg;
    logic [15:0] concavity_reg;

    logic                  outlet_reg, diag_reg;
    logic [31:0]           pix_reg;
    cca_pkg::opnd_sel_t    sel_reg;
    logic [3:0]            cnt_reg;
    logic [MW-1:0]         m_reg;
    logic [4:0]            msb_reg;
    logic [15:0]           frac_reg;
    logic signed [LW-1:0]  lsum_reg;
    logic [20:0]           logc_reg;
    logic signed [FW-1:0]  f_reg;
    logic [31:0]           acc_reg;
    logic [31:0]           running_reg;
    logic                  out_valid_reg, saturated_reg;
    logic [31:0]           chi_value_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            initial_chi_reg <= cca_pkg::INITIAL_CHI_RST;
            concavity_reg   <= cca_pkg::CONCAVITY_RST;
            ref_area_reg    <= cca_pkg::REF_AREA_RST;
            cell_size_reg   <= cca_pkg::CELL_SIZE_RST;
        end
        else if (cfg_write) begin
            unique case (cca_pkg::reg_idx_t'(cfg_addr))
                cca_pkg::REG_INITIAL_CHI: initial_chi_reg <= cfg_wdata;
                cca_pkg::REG_CONCAVITY:   concavity_reg   <= cfg_wdata[15:0];
                cca_pkg::REG_REF_AREA:    ref_area_reg    <= cfg_wdata;
                cca_pkg::REG_CELL_SIZE:   cell_size_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // operand normaliser
    logic [31:0]   norm_src, norm_x;
    logic [4:0]    norm_msb;
    logic [MW-1:0] norm_mant;

    always_comb
    begin
        case (sel_reg)
            cca_pkg::OPND_AREA: norm_src = ref_area_reg;
            cca_pkg::OPND_CELL: norm_src = cell_size_reg;
            default:            norm_src = pix_reg;
        endcase
        norm_x = (norm_src == 32'd0) ? 32'd1 : norm_src;
    end

    cca_norm u_norm (
        .x    (norm_x),
        .msb  (norm_msb),
        .mant (norm_mant)
    );

    // shared multiplier
    logic signed [OW-1:0]  mul_a, mul_b;
    logic signed [PRW-1:0] prod;
    logic [31:0]           root_val;

    assign root_val = cca_pkg::ROOTS[cnt_reg];

    always_comb
    begin
        case (state_reg)
            cca_pkg::ST_SCALE:
            begin
                mul_a = OW'(concavity_reg);
                mul_b = OW'(lsum_reg);
            end
            cca_pkg::ST_EXP:
            begin
                mul_a = OW'(acc_reg);
                mul_b = OW'(root_val);
            end
            default:
            begin
                mul_a = OW'(m_reg);
                mul_b = OW'(m_reg);
            end
        endcase
        prod = mul_a * mul_b;
    end

    // log2 squaring step
    logic [32:0]    sq;
    logic           log_bit;
    logic [MW-1:0]  m_step;
    logic [15:0]    frac_step;
    logic [20:0]    log_val;

    always_comb
    begin
        sq        = prod[62:30];
        log_bit   = sq[31];
        m_step    = log_bit ? sq[31:1] : sq[30:0];
        frac_step = {frac_reg[14:0], log_bit};
        log_val   = {msb_reg, frac_step};
    end

    // exponent and term
    logic signed [FW-1:0] f_calc;
    logic signed [11:0]   k;
    logic signed [12:0]   shr;
    logic [TW-1:0]        term, t_up;
    logic signed [TW:0]   sum;

    always_comb
    begin
        f_calc = FW'($signed(prod[41:14])) + $signed(FW'(logc_reg))
                 + (diag_reg ? $signed(cca_pkg::HALF_STEP) : $signed(FW'(0)));
        k      = f_reg[FW-1:16];
        shr    = 13'sd30 - 13'(k);
        t_up   = TW'(acc_reg) << (2'(k) - 2'd2);
        if (k >= 12'sd33) begin
            term = cca_pkg::TERM_CAP;
        end
        else if (k >= 12'sd30) begin
            t_up = TW'(acc_reg) << 2'(k - 12'sd30);
            term = (t_up > cca_pkg::TERM_CAP) ? cca_pkg::TERM_CAP : t_up;
        end
        else if (shr >= 13'sd32) begin
            term = '0;
        end
        else begin
            term = TW'(acc_reg >> shr[4:0]);
        end
        sum = $signed({{(TW-31){running_reg[31]}}, running_reg}) + $signed({1'b0, term});
    end

    // sequencer
    logic out_free;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == cca_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cca_pkg::ST_IDLE:
                if (in_valid) begin
                    state_next = is_outlet ? cca_pkg::ST_FINISH : cca_pkg::ST_LOAD;
                end
            cca_pkg::ST_LOAD:
                state_next = cca_pkg::ST_LOG;
            cca_pkg::ST_LOG:
                if (cnt_reg == 4'(cca_pkg::LOG_STEPS - 1)) begin
                    state_next = (sel_reg == cca_pkg::OPND_PIXEL) ? cca_pkg::ST_SCALE
                                                                  : cca_pkg::ST_LOAD;
                end
            cca_pkg::ST_SCALE:
                state_next = cca_pkg::ST_EXP;
            cca_pkg::ST_EXP:
                if (cnt_reg == 4'(cca_pkg::EXP_STEPS - 1)) begin
                    state_next = cca_pkg::ST_FINISH;
                end
            cca_pkg::ST_FINISH:
                if (out_free) begin
                    state_next = cca_pkg::ST_IDLE;
                end
            default:
                state_next = cca_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= cca_pkg::ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            cca_pkg::ST_IDLE:
            begin
                outlet_reg <= is_outlet;
                diag_reg   <= diagonal_step;
                pix_reg    <= pixel_count & PIX_MASK;
                sel_reg    <= cca_pkg::OPND_AREA;
            end
            cca_pkg::ST_LOAD:
            begin
                m_reg    <= norm_mant;
                msb_reg  <= norm_msb;
                frac_reg <= '0;
                cnt_reg  <= '0;
            end
            cca_pkg::ST_LOG:
            begin
                m_reg    <= m_step;
                frac_reg <= frac_step;
                cnt_reg  <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(cca_pkg::LOG_STEPS - 1)) begin
                    case (sel_reg)
                        cca_pkg::OPND_AREA:
                        begin
                            lsum_reg <= $signed(LW'(log_val)) + $signed(cca_pkg::LOG_BIAS);
                            sel_reg  <= cca_pkg::OPND_CELL;
                        end
                        cca_pkg::OPND_CELL:
                        begin
                            lsum_reg <= lsum_reg - $signed(LW'({log_val, 1'b0}));
                            logc_reg <= log_val;
                            sel_reg  <= cca_pkg::OPND_PIXEL;
                        end
                        default:
                            lsum_reg <= lsum_reg - $signed(LW'(log_val));
                    endcase
                end
            end
            cca_pkg::ST_SCALE:
            begin
                f_reg   <= f_calc;
                acc_reg <= cca_pkg::Q30_ONE;
                cnt_reg <= '0;
            end
            cca_pkg::ST_EXP:
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (f_reg[4'd15 - cnt_reg]) begin
                    acc_reg <= prod[61:30];
                end
            end
            default: ;
        endcase
    end

    // running chi and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == cca_pkg::ST_FINISH && out_free) begin
                out_valid_reg <= 1'b1;
                if (outlet_reg) begin
                    running_reg <= initial_chi_reg;
                end
                else if (sum > $signed({4'd0, cca_pkg::CHI_MAX})) begin
                    running_reg <= cca_pkg::CHI_MAX;
                end
                else begin
                    running_reg <= sum[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == cca_pkg::ST_FINISH && out_free) begin
            if (outlet_reg) begin
                chi_value_reg <= initial_chi_reg;
                saturated_reg <= 1'b0;
            end
            else if (sum > $signed({4'd0, cca_pkg::CHI_MAX})) begin
                chi_value_reg <= cca_pkg::CHI_MAX;
                saturated_reg <= 1'b1;
            end
            else begin
                chi_value_reg <= sum[31:0];
                saturated_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign chi_value = chi_value_reg;
    assign saturated = saturated_reg;

`ifndef SYNTHESIS
    a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> chi_value == cca_pkg::CHI_MAX)
        else $error("saturated result not at maximum");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after accept");
    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cca_pkg::ST_FINISH && out_free |=> out_valid && in_ready)
        else $error("finished node not presented");
    a_chi_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> chi_value == running_reg)
        else $error("output chi differs from running chi");
`endif

endmodule

@@ tb/tb_top.sv @@
module tb_top;

    typedef struct packed {
        logic        outlet;
        logic        diag;
        logic [31:0] pix;
    } node_t;

    typedef struct packed {
        logic [31:0] chi;
        logic        sat;
    } chi_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        is_outlet;
    logic        diagonal_step;
    logic [31:0] pixel_count;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] chi_value;
    logic        saturated;

    node_t    node_q[$];
    chi_res_t chi_q[$];
    int       n_err;
    bit       quiet;
    int       idle_cnt;

    // shadow of the register file and running chi
    logic [31:0] sh_init;
    logic [15:0] sh_conc;
    logic [31:0] sh_area;
    logic [31:0] sh_cell;
    logic [31:0] chi_run;

    chi_coordinate_accumulator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .is_outlet(is_outlet), .diagonal_step(diagonal_step), .pixel_count(pixel_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .chi_value(chi_value), .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = x;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v && b != 0)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // log2 in Q.16 by repeated squaring of a Q1.30 mantissa
    function automatic longint log2_fix(input logic [63:0] x);
        int          msb;
        logic [63:0] m;
        longint      frac;
        msb  = 0;
        frac = 0;
        while (msb < 63 && (x >> (msb + 1)) != 0)
            msb++;
        m = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
        for (int i = 0; i < 16; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                frac = frac | 1;
                m    = m >> 1;
            end
        end
        return longint'(msb) * 65536 + frac;
    endfunction

    function automatic logic [63:0] pow2_term(input longint f_exp);
        longint      k;
        logic [15:0] f;
        logic [63:0] acc;
        logic [63:0] r;
        logic [63:0] t;
        k   = f_exp >>> 16;
        f   = f_exp[15:0];
        acc = 64'd1 << 30;
        r   = 64'd2 << 30;
        for (int i = 1; i <= 16; i++)
        begin
            r = int_sqrt(r << 30);
            if (f[16 - i])
                acc = (acc * r) >> 30;
        end
        if (k >= 33)
            return 64'd1 << 33;
        if (k >= 30)
        begin
            t = acc << (k - 30);
            return (t > (64'd1 << 33)) ? (64'd1 << 33) : t;
        end
        if (30 - k >= 63)
            return 0;
        return acc >> (30 - k);
    endfunction

    function automatic chi_res_t next_chi(input node_t n);
        chi_res_t    r;
        logic [63:0] a;
        logic [63:0] c;
        logic [63:0] p;
        longint      la, lc, lp, lsum, pw, fx, sum;
        r.sat = 1'b0;
        if (n.outlet)
            chi_run = sh_init;
        else
        begin
            a    = (sh_area == 0) ? 64'd1 : {32'd0, sh_area};
            c    = (sh_cell == 0) ? 64'd1 : {32'd0, sh_cell};
            p    = (n.pix == 0) ? 64'd1 : {32'd0, n.pix};
            la   = log2_fix(a) - 16 * 65536;
            lc   = log2_fix(c) - 16 * 65536;
            lp   = log2_fix(p);
            lsum = la - lp - 2 * lc;
            pw   = (longint'(sh_conc) * lsum) >>> 14;
            fx   = lc + pw + (n.diag ? 32768 : 0) + 16 * 65536;
            sum  = longint'($signed(chi_run)) + longint'(pow2_term(fx));
            if (sum > 64'sh7FFF_FFFF)
            begin
                sum   = 64'sh7FFF_FFFF;
                r.sat = 1'b1;
            end
            chi_run = sum[31:0];
        end
        r.chi = chi_run;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
        $display("error: %s got %h expected %h at %0t", what, got, exp_v, $time);
        n_err++;
    endtask

    // driver
    int gap;
    always @(posedge clk or negedge rst_n)
    begin
        node_t n;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            is_outlet     <= 1'b0;
            diagonal_step <= 1'b0;
            pixel_count   <= 32'd0;
            gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                chi_q.insert(chi_q.size(),
                             next_chi('{is_outlet, diagonal_step, pixel_count}));
            if (!in_valid || in_ready)
            begin
                if (gap > 0)
                begin
                    gap--;
                    in_valid <= 1'b0;
                end
                else if (node_q.size() > 0)
                begin
                    n = node_q.pop_front();
                    is_outlet     <= n.outlet;
                    diagonal_step <= n.diag;
                    pixel_count   <= n.pix;
                    in_valid      <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        gap = $urandom_range(1, 18);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    int stall;
    always @(posedge clk or negedge rst_n)
    begin
        chi_res_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (chi_q.size() == 0)
                    report("unexpected transaction chi", chi_value, 32'd0);
                else
                begin
                    e = chi_q.pop_front();
                    if (chi_value !== e.chi)
                        report("chi_value", chi_value, e.chi);
                    if (saturated !== e.sat)
                        report("saturated", {31'd0, saturated}, {31'd0, e.sat});
                end
            end
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    stall = $urandom_range(1, 18);
            end
        end
    end

    // watchdog on cycles with no transaction on either side and no register write
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= 5000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input cca_pkg::reg_idx_t idx, input logic [31:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        case (idx)
            cca_pkg::REG_INITIAL_CHI: sh_init = v;
            cca_pkg::REG_CONCAVITY:   sh_conc = v[15:0];
            cca_pkg::REG_REF_AREA:    sh_area = v;
            cca_pkg::REG_CELL_SIZE:   sh_cell = v;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] ic, input logic [31:0] cc,
                            input logic [31:0] ra, input logic [31:0] cs);
        write_reg(cca_pkg::REG_INITIAL_CHI, ic);
        write_reg(cca_pkg::REG_CONCAVITY, cc);
        write_reg(cca_pkg::REG_REF_AREA, ra);
        write_reg(cca_pkg::REG_CELL_SIZE, cs);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic add_node(input bit o, input bit d, input logic [31:0] p);
        node_q.insert(node_q.size(), '{o, d, p});
    endtask

    task automatic drain();
        while (node_q.size() > 0 || in_valid || chi_q.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // random channels: an outlet then upstream nodes, some stray outlets
    task automatic add_random(input int cnt);
        logic [31:0] p;
        add_node(1'b1, 1'($urandom_range(0, 1)), $urandom);
        for (int i = 1; i < cnt; i++)
        begin
            case ($urandom_range(0, 3))
                0: p = $urandom;
                1: p = $urandom_range(0, 16);
                default: p = $urandom_range(1, 5000);
            endcase
            add_node($urandom_range(0, 14) == 0, 1'($urandom_range(0, 1)), p);
        end
    endtask

    initial
    begin
        n_err     = 0;
        quiet     = 1'b0;
        idle_cnt  = 0;
        cfg_write = 1'b0;
        cfg_addr  = cca_pkg::REG_INITIAL_CHI;
        cfg_wdata = 32'd0;
        sh_init   = cca_pkg::INITIAL_CHI_RST;
        sh_conc   = cca_pkg::CONCAVITY_RST;
        sh_area   = cca_pkg::REF_AREA_RST;
        sh_cell   = cca_pkg::CELL_SIZE_RST;
        chi_run   = 32'd0;
        rst_n     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings: no outlet first, extremes of pixel count
        add_node(1'b0, 1'b0, 32'd1);
        add_node(1'b1, 1'b0, 32'd1);
        add_node(1'b0, 1'b0, 32'd0);
        add_node(1'b0, 1'b1, 32'd1);
        add_node(1'b0, 1'b0, 32'hFFFF_FFFF);
        add_node(1'b0, 1'b1, 32'hFFFF_FFFF);
        add_node(1'b1, 1'b1, 32'h8000_0000);
        add_node(1'b0, 1'b1, 32'h5555_5555);
        add_node(1'b0, 1'b0, 32'hAAAA_AAAA);
        drain();

        // overflow: big reference area, steep exponent, start near maximum
        set_regs(32'h7FFF_0000, 32'd65535, 32'hFFFF_FFFF, 32'h0001_0000);
        add_node(1'b1, 1'b0, 32'd1);
        add_node(1'b0, 1'b0, 32'd1);
        add_node(1'b0, 1'b1, 32'd1);
        add_node(1'b0, 1'b0, 32'hFFFF_FFFF);
        drain();

        // zero operands, zero exponent, most negative start
        set_regs(32'h8000_0000, 32'd0, 32'd0, 32'd0);
        add_node(1'b1, 1'b0, 32'd0);
        add_node(1'b0, 1'b0, 32'd0);
        add_node(1'b0, 1'b1, 32'd7);
        drain();
        set_regs(32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF);
        add_node(1'b1, 1'b0, 32'd3);
        add_node(1'b0, 1'b1, 32'd1);
        add_node(1'b0, 1'b0, 32'hFFFF_FFFF);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_regs(32'd0, 32'd7373, 32'd65536, 32'd65536);
                1: set_regs(32'h0010_0000, 32'd8192, 32'h0064_0000, 32'h001E_0000);
                2: set_regs($urandom, $urandom_range(0, 65535), $urandom, $urandom);
                3: set_regs(32'h7000_0000, 32'd65535, 32'h8000_0000, 32'd1);
                4: set_regs(32'hC000_0000, 32'd16384, 32'd65536, 32'h0000_4000);
                5: set_regs($urandom, $urandom_range(4000, 12000), $urandom, $urandom);
                6: set_regs(32'd0, 32'd6000, 32'h0010_0000, 32'h000A_0000);
                default:
                begin
                    quiet = 1'b1;
                    set_regs($urandom, $urandom_range(0, 65535), $urandom, $urandom);
                end
            endcase
            for (int ch = 0; ch < 5; ch++)
                add_random($urandom_range(10, 30));
            drain();
        end

        if (n_err == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/cca_pkg.sv
hw/rtl/cca_norm.sv
hw/rtl/chi_coordinate_accumulator.sv
tb/tb_top.sv
